/* src/typed_block_pool_allocator_top_defines.svh */
// Assertion helpers for the allocator top-level RTL.
`ifndef TYPED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define TYPED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TBPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TBPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tbpa_pkg.sv */
`timescale 1ns / 1ps

package tbpa_pkg;

  // Table geometry
  localparam int POOL_ENTRIES = 16;
  localparam int IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int TYPE_W   = 8;
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 15;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_ALLOCATE = 2'd1,
    CMD_RELEASE  = 2'd2,
    CMD_IGNORE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NONE_FREE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ZERO_ADDR = 3'd4
  } status_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [TYPE_W-1:0] type_id;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
    logic              in_use;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/tbpa_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module tbpa_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/typed_block_pool_allocator_top.sv */
`timescale 1ns / 1ps
// Flow: register, ignored command, or allocate/release on an empty table is answered from
//   idle; allocate/release otherwise scans from entry 0 and either writes back the hit entry
//   in S_WRITE before answering or, on a miss, answers after the last registered entry.
// Throughput: one command at a time; a scan compares one entry per cycle through the single
//   RAM read port, busy high until the result. Results are one-cycle done beats; no stall.
// Reset (rst, synchronous) clears state, entry count and done; entries stay undefined until registered.

module typed_block_pool_allocator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [tbpa_pkg::CMD_W-1:0]     command,
  input  logic [tbpa_pkg::TYPE_W-1:0]    type_id,
  input  logic [tbpa_pkg::ADDR_W-1:0]    block_address,
  input  logic [tbpa_pkg::SIZE_W-1:0]    block_size,
  output logic                           done,
  output logic [tbpa_pkg::STATUS_W-1:0]  status,
  output logic [tbpa_pkg::ADDR_W-1:0]    granted_address,
  output logic [tbpa_pkg::SIZE_W-1:0]    granted_size
);

  import tbpa_pkg::*;

  `include "typed_block_pool_allocator_top_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic [IDX_W-1:0]  hit_idx, hit_idx_next;
  entry_t            hit_word, hit_word_next;
  cmd_t              cmd_q, cmd_q_next;
  logic [TYPE_W-1:0] type_q, type_q_next;
  logic [ADDR_W-1:0] addr_q, addr_q_next;

  logic                done_next;
  logic [STATUS_W-1:0] status_next;
  logic [ADDR_W-1:0]   granted_address_next;
  logic [SIZE_W-1:0]   granted_size_next;

  // RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;

  logic  accept;
  cmd_t  cmd_in;
  logic  last_entry;

  // Shared compare unit: type key for allocate, address key for release
  logic [ADDR_W-1:0] cmp_a, cmp_b;
  logic              key_eq, match;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign cmd_in   = cmd_t'(command);
  assign rd_entry = entry_t'(ram_rdata);

  assign last_entry = ((CNT_W'(scan_idx) + CNT_W'(1)) == entry_count);

  always_comb begin
    if (cmd_q == CMD_ALLOCATE) begin
      cmp_a = ADDR_W'(rd_entry.type_id);
      cmp_b = ADDR_W'(type_q);
    end else begin
      cmp_a = rd_entry.address;
      cmp_b = addr_q;
    end
  end

  assign key_eq = (cmp_a == cmp_b);
  assign match  = key_eq && ((cmd_q == CMD_RELEASE) || !rd_entry.in_use);

  // Read address: entry 0 on accept, then one ahead of the entry being compared
  assign ram_raddr = (state == S_SCAN) ? (scan_idx + IDX_W'(1)) : '0;

  tbpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_next           = state;
    entry_count_next     = entry_count;
    scan_idx_next        = scan_idx;
    hit_idx_next         = hit_idx;
    hit_word_next        = hit_word;
    cmd_q_next           = cmd_q;
    type_q_next          = type_q;
    addr_q_next          = addr_q;
    done_next            = 1'b0;
    status_next          = status;
    granted_address_next = granted_address;
    granted_size_next    = granted_size;
    ram_we               = 1'b0;
    ram_waddr            = entry_count[IDX_W-1:0];
    ram_wdata            = '{type_id: type_id, address: block_address,
                             size: block_size, in_use: 1'b0};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q_next           = cmd_in;
          type_q_next          = type_id;
          addr_q_next          = block_address;
          scan_idx_next        = '0;
          granted_address_next = '0;
          granted_size_next    = '0;
          unique case (cmd_in)
            CMD_REGISTER: begin
              done_next = 1'b1;
              if (block_address == '0) begin
                status_next = ST_ZERO_ADDR;
              end else if (entry_count >= CNT_W'(POOL_ENTRIES)) begin
                status_next = ST_FULL;
              end else begin
                status_next      = ST_OK;
                ram_we           = 1'b1;
                entry_count_next = entry_count + CNT_W'(1);
              end
            end
            CMD_ALLOCATE, CMD_RELEASE: begin
              if (entry_count == '0) begin
                done_next   = 1'b1;
                status_next = (cmd_in == CMD_ALLOCATE) ? ST_NONE_FREE : ST_NOT_FOUND;
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_IGNORE: begin
              done_next   = 1'b1;
              status_next = ST_OK;
            end
            default: begin
              done_next   = 1'b1;
              status_next = ST_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (match) begin
          hit_idx_next         = scan_idx;
          hit_word_next        = rd_entry;
          hit_word_next.in_use = (cmd_q == CMD_ALLOCATE);
          state_next           = S_WRITE;
        end else if (last_entry) begin
          done_next   = 1'b1;
          status_next = (cmd_q == CMD_ALLOCATE) ? ST_NONE_FREE : ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end

      S_WRITE: begin
        ram_we      = 1'b1;
        ram_waddr   = hit_idx;
        ram_wdata   = hit_word;
        done_next   = 1'b1;
        status_next = ST_OK;
        if (cmd_q == CMD_ALLOCATE) begin
          granted_address_next = hit_word.address;
          granted_size_next    = hit_word.size;
        end
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      done        <= done_next;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    scan_idx        <= scan_idx_next;
    hit_idx         <= hit_idx_next;
    hit_word        <= hit_word_next;
    cmd_q           <= cmd_q_next;
    type_q          <= type_q_next;
    addr_q          <= addr_q_next;
    status          <= status_next;
    granted_address <= granted_address_next;
    granted_size    <= granted_size_next;
  end

  // Checks
  `TBPA_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= CNT_W'(POOL_ENTRIES),
    "entry count beyond table depth")
  `TBPA_ASSERT_NOW(a_grant_zero, done && (status != ST_OK),
    (granted_address == '0) && (granted_size == '0),
    "nonzero grant on failed command")
  `TBPA_ASSERT_NEXT(a_write_answers, state == S_WRITE, done && (status == ST_OK),
    "write-back did not produce an ok result")
  `TBPA_ASSERT_NOW(a_done_source, done,
    $past(accept) || ($past(state) == S_SCAN) || ($past(state) == S_WRITE),
    "result beat without a command")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tbpa_pkg::*;

  // One command beat as queued for the driver; hold marks a drain point
  typedef struct {
    bit                hold;
    cmd_t              cmd;
    logic [TYPE_W-1:0] type_id;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } pool_req_t;

  // One result beat
  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } grant_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    command = '0;
  logic [TYPE_W-1:0]   type_id = '0;
  logic [ADDR_W-1:0]   block_address = '0;
  logic [SIZE_W-1:0]   block_size = '0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted_address;
  logic [SIZE_W-1:0]   granted_size;

  typed_block_pool_allocator_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .type_id         (type_id),
    .block_address   (block_address),
    .block_size      (block_size),
    .done            (done),
    .status          (status),
    .granted_address (granted_address),
    .granted_size    (granted_size)
  );

  // Predicted table contents
  logic [TYPE_W-1:0] tbl_type [POOL_ENTRIES];
  logic [ADDR_W-1:0] tbl_addr [POOL_ENTRIES];
  logic [SIZE_W-1:0] tbl_size [POOL_ENTRIES];
  bit                tbl_used [POOL_ENTRIES];
  int                tbl_count = 0;

  pool_req_t feed_q[$];
  grant_t    grant_q[$];
  pool_req_t cur_req;
  int        gap_left;
  int        burst_left;
  int        n_sent = 0;
  int        n_err = 0;
  int        cmd_seen [4];
  int        st_seen [8];
  logic [ADDR_W-1:0] addr_pool [12];

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Pool behavior: apply one command to the predicted table
  task automatic pool_apply(input pool_req_t r, output grant_t g);
    bit hit;
    hit      = 1'b0;
    g.status = ST_OK;
    g.addr   = '0;
    g.size   = '0;
    case (r.cmd)
      CMD_REGISTER: begin
        // zero address wins over full
        if (r.addr == '0) g.status = ST_ZERO_ADDR;
        else if (tbl_count >= POOL_ENTRIES) g.status = ST_FULL;
        else begin
          tbl_type[tbl_count] = r.type_id;
          tbl_addr[tbl_count] = r.addr;
          tbl_size[tbl_count] = r.size;
          tbl_used[tbl_count] = 1'b0;
          tbl_count++;
        end
      end
      CMD_ALLOCATE: begin
        g.status = ST_NONE_FREE;
        for (int i = 0; i < tbl_count && !hit; i++) begin
          if (tbl_type[i] == r.type_id && !tbl_used[i]) begin
            hit         = 1'b1;
            tbl_used[i] = 1'b1;
            g.status    = ST_OK;
            g.addr      = tbl_addr[i];
            g.size      = tbl_size[i];
          end
        end
      end
      CMD_RELEASE: begin
        // first matching address only
        g.status = ST_NOT_FOUND;
        for (int i = 0; i < tbl_count && !hit; i++) begin
          if (tbl_addr[i] == r.addr) begin
            hit         = 1'b1;
            tbl_used[i] = 1'b0;
            g.status    = ST_OK;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_req(input bit hold, input cmd_t c, input logic [TYPE_W-1:0] t,
                           input logic [ADDR_W-1:0] a, input logic [SIZE_W-1:0] s);
    pool_req_t r;
    r.hold    = hold;
    r.cmd     = c;
    r.type_id = t;
    r.addr    = a;
    r.size    = s;
    feed_q.push_back(r);
  endtask

  function automatic logic [TYPE_W-1:0] pick_type();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return TYPE_W'($urandom_range(0, 3));
    if (sel == 7) return '1;
    return TYPE_W'($urandom);
  endfunction

  // Stimulus
  initial begin : stim
    int   n_items;
    int   sel;
    cmd_t c;
    logic [ADDR_W-1:0] a;

    addr_pool[0] = 32'hFFFF_FFFF;
    addr_pool[1] = 32'h0000_0001;
    addr_pool[2] = 32'h0000_1000;
    for (int i = 3; i < 12; i++) begin
      addr_pool[i] = $urandom;
      if (addr_pool[i] == '0) addr_pool[i] = 32'h8000_0000;
    end

    // Directed: empty table, extremes, duplicates, misses, ignored command
    queue_req(0, CMD_RELEASE,  8'h00, 32'h0,         15'h0);
    queue_req(0, CMD_ALLOCATE, 8'h00, 32'h0,         15'h0);
    queue_req(0, CMD_REGISTER, 8'hFF, 32'h0,         15'h7FFF);
    queue_req(0, CMD_REGISTER, 8'h00, 32'h0000_0001, 15'h0);
    queue_req(0, CMD_REGISTER, 8'hFF, 32'hFFFF_FFFF, 15'h7FFF);
    queue_req(0, CMD_REGISTER, 8'h05, 32'h0000_1000, 15'h1234);
    queue_req(0, CMD_REGISTER, 8'h05, 32'h0000_1000, 15'h4321);
    queue_req(0, CMD_ALLOCATE, 8'h05, 32'hFFFF_FFFF, 15'h7FFF);
    queue_req(0, CMD_ALLOCATE, 8'h05, 32'h0,         15'h0);
    queue_req(0, CMD_ALLOCATE, 8'h05, 32'h0,         15'h0);
    queue_req(0, CMD_RELEASE,  8'hFF, 32'h0000_1000, 15'h7FFF);
    queue_req(0, CMD_RELEASE,  8'h00, 32'h0000_1000, 15'h0);
    queue_req(0, CMD_ALLOCATE, 8'h05, 32'h0,         15'h0);
    queue_req(0, CMD_RELEASE,  8'h00, 32'h0000_2000, 15'h0);
    queue_req(0, CMD_RELEASE,  8'h00, 32'h0,         15'h0);
    queue_req(0, CMD_IGNORE,   8'hFF, 32'hFFFF_FFFF, 15'h7FFF);
    queue_req(0, CMD_ALLOCATE, 8'hFF, 32'h0,         15'h0);
    queue_req(0, CMD_ALLOCATE, 8'h00, 32'h0,         15'h0);
    queue_req(0, CMD_RELEASE,  8'h00, 32'hFFFF_FFFF, 15'h0);
    queue_req(1, CMD_IGNORE,   8'h00, 32'h0,         15'h0);

    // Random: table fills early, then allocate/release churn with full-table registers
    n_items = 0;
    while (n_items < 1300) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) c = CMD_REGISTER;
      else if (sel < 60) c = CMD_ALLOCATE;
      else if (sel < 95) c = CMD_RELEASE;
      else c = CMD_IGNORE;

      sel = $urandom_range(0, 99);
      if (sel < 75) a = addr_pool[$urandom_range(0, 11)];
      else if (sel < 83) a = '0;
      else a = $urandom;

      queue_req(0, c, pick_type(), a, SIZE_W'($urandom_range(0, 32767)));
      if (c != CMD_IGNORE) n_items++;
      if (n_items % 250 == 249) queue_req(1, CMD_IGNORE, '0, '0, '0);
    end
  end

  // Driver: bursts of beats with random gaps, drains at hold markers
  always @(posedge clk) begin : drv
    grant_t g;
    bit     go;
    if (rst) begin
      start      <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      go = 1'b0;
      // beat accepted: predict its result
      if (start && !busy) begin
        pool_apply(cur_req, g);
        grant_q.push_back(g);
        n_sent++;
        cmd_seen[cur_req.cmd]++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      // slot free: gap, drain, or next beat
      if (!start || !busy) begin
        if (gap_left > 0) gap_left--;
        else begin
          while (feed_q.size() > 0 && feed_q[0].hold && grant_q.size() == 0)
            void'(feed_q.pop_front());
          if (feed_q.size() > 0 && !feed_q[0].hold) begin
            cur_req = feed_q.pop_front();
            go      = 1'b1;
          end
        end
        start <= go;
        if (go) begin
          command       <= cur_req.cmd;
          type_id       <= cur_req.type_id;
          block_address <= cur_req.addr;
          block_size    <= cur_req.size;
        end
      end
    end
  end

  // Monitor: compare each done beat with the oldest prediction
  always @(posedge clk) begin : mon
    grant_t want;
    if (!rst && done) begin
      st_seen[status]++;
      if (grant_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected result: status %0d addr %h size %h",
                   status, granted_address, granted_size);
      end else begin
        want = grant_q.pop_front();
        if (status !== want.status || granted_address !== want.addr ||
            granted_size !== want.size) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp status %0d addr %h size %h, got status %0d addr %h size %h",
                     want.status, want.addr, want.size,
                     status, granted_address, granted_size);
        end
      end
    end
  end

  // End of run
  initial begin : finish_run
    wait (!rst);
    while (feed_q.size() != 0 || start || grant_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    $display("%0d commands: %0d register, %0d allocate, %0d release, %0d ignored",
             n_sent, cmd_seen[CMD_REGISTER], cmd_seen[CMD_ALLOCATE],
             cmd_seen[CMD_RELEASE], cmd_seen[CMD_IGNORE]);
    $display("results: ok %0d, full %0d, none free %0d, not found %0d, zero addr %0d, errors %0d",
             st_seen[ST_OK], st_seen[ST_FULL], st_seen[ST_NONE_FREE],
             st_seen[ST_NOT_FOUND], st_seen[ST_ZERO_ADDR], n_err);
    if (n_err == 0 && grant_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/tbpa_pkg.sv
src/tbpa_ram.sv
src/typed_block_pool_allocator_top.sv
tb/sv/tb.sv
